>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the slot table RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/grst_pkg.sv
// Package for the generational slot table: sizes, codes, slot word layout
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package grst_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int IDX_FW     = 12;
  localparam int GEN_W      = 32;
  localparam int REF_W      = 32;
  localparam int SCOPE_W    = 32;
  localparam int KEY_W      = 64;
  localparam int LIVE_W     = 13;
  localparam int TOTAL_W    = 32;
  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_RELEASE  = 2'd1,
    ACT_VALIDATE = 2'd2,
    ACT_SCOPE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_NEW    = 3'd0,
    ST_SHARED = 3'd1,
    ST_FULL   = 3'd2,
    ST_FAILED = 3'd3,
    ST_STALE  = 3'd4,
    ST_FREED  = 3'd5,
    ST_HELD   = 3'd6,
    ST_DONE   = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_HND_RD,
    S_HND_EV,
    S_CLM_RD,
    S_CLM_EV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCOPE_W-1:0] scope;
    logic [REF_W-1:0]   refc;
    logic [GEN_W-1:0]   gen;
  } slot_word_t;

  typedef struct packed {
    logic    capture;
    logic    scan_clr;
    logic    scan_inc;
    logic    rd_scan;
    logic    rd_hnd;
    logic    rd_clm;
    logic    ev_scan;
    logic    ev_hnd;
    logic    ev_clm;
    logic    st_en;
    status_t st_code;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    scope_zero;
    logic    hnd_pre_ok;
    logic    scan_last;
    logic    scan_match;
    logic    free_now;
    logic    load_ok;
    logic    hnd_match;
    logic    out_busy;
  } sts_t;

endpackage

>>> hw/rtl/grst_ctrl.sv
// Controller state machine for the slot table: sequences scans, handle
// checks and claims. Depends on grst_pkg.
`timescale 1ns / 1ps

module grst_ctrl import grst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.act)
          ACT_LOAD:  state_next = S_SCAN_RD;
          ACT_SCOPE: state_next = sts.scope_zero ? S_FIN : S_SCAN_RD;
          default:   state_next = sts.hnd_pre_ok ? S_HND_RD : S_FIN;
        endcase
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (sts.act == ACT_LOAD && sts.scan_match) begin
          state_next = S_FIN;
        end else if (sts.scan_last) begin
          if (sts.act == ACT_LOAD && sts.load_ok && sts.free_now) state_next = S_CLM_RD;
          else state_next = S_FIN;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_HND_RD: state_next = S_HND_EV;
      S_HND_EV: state_next = S_FIN;
      S_CLM_RD: state_next = S_CLM_EV;
      S_CLM_EV: state_next = S_FIN;
      S_FIN: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.st_code = ST_STALE;
    s_tready = (state == S_IDLE);
    case (state)
      S_IDLE: cmd.capture = s_tvalid;
      S_DISPATCH: begin
        case (sts.act)
          ACT_LOAD: cmd.scan_clr = 1'b1;
          ACT_SCOPE: begin
            cmd.scan_clr = 1'b1;
            cmd.st_en    = sts.scope_zero;
          end
          default: cmd.st_en = !sts.hnd_pre_ok;
        endcase
      end
      S_SCAN_RD: cmd.rd_scan = 1'b1;
      S_SCAN_EV: begin
        cmd.ev_scan = 1'b1;
        if (!(sts.act == ACT_LOAD && sts.scan_match)) begin
          if (sts.scan_last) begin
            if (sts.act == ACT_SCOPE) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_DONE;
            end else if (!sts.load_ok) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_FAILED;
            end else if (!sts.free_now) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_FULL;
            end
          end else begin
            cmd.scan_inc = 1'b1;
          end
        end
      end
      S_HND_RD: cmd.rd_hnd = 1'b1;
      S_HND_EV: begin
        cmd.ev_hnd = 1'b1;
        if (sts.act == ACT_VALIDATE) begin
          cmd.st_en   = 1'b1;
          cmd.st_code = sts.hnd_match ? ST_DONE : ST_STALE;
        end else begin
          cmd.st_en = !sts.hnd_match;
        end
      end
      S_CLM_RD: cmd.rd_clm = 1'b1;
      S_CLM_EV: cmd.ev_clm = 1'b1;
      S_FIN: cmd.fin = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/grst_dp.sv
// Datapath for the slot table: slot memory, loaded and written flags,
// counters, captured transaction and output register. Depends on grst_pkg.
`timescale 1ns / 1ps

module grst_dp import grst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [SCOPE_W-1:0]    cfg_wdata,
  input  logic [1:0]            s_tuser,
  input  logic [143:0]          s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [95:0]           m_tdata,
  output logic [2:0]            m_tuser,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  slot_word_t mem [SLOT_COUNT];
  slot_word_t rd_word;
  slot_word_t wd;
  logic [SLOT_COUNT-1:0] loaded;
  logic [SLOT_COUNT-1:0] written;
  logic                  rd_loaded;
  logic                  rd_init;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      ra;
  logic                  re;
  logic                  we;

  logic [SCOPE_W-1:0] cur_scope;
  action_t            cap_act;
  logic [KEY_W-1:0]   cap_key;
  logic               cap_ok;
  logic [IDX_FW-1:0]  cap_idx;
  logic [GEN_W-1:0]   cap_gen;
  logic [SCOPE_W-1:0] cap_scope;

  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   free_idx;
  logic               have_free;
  logic [LIVE_W-1:0]  live;
  logic [TOTAL_W-1:0] claims;

  status_t            res_status;
  logic [IDX_FW-1:0]  res_idx;
  logic [GEN_W-1:0]   res_gen;

  logic [GEN_W-1:0] eff_gen;
  logic key_hit;
  logic scope_hit;
  logic hnd_hit;
  logic share_en;
  logic drop_en;
  logic drop_free;
  logic [GEN_W-1:0] claim_gen;

  // Hold the scope register
  always_ff @(posedge clk) begin
    if (rst) cur_scope <= '0;
    else if (cfg_we) cur_scope <= cfg_wdata;
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_act   <= action_t'(s_tuser);
      cap_key   <= s_tdata[63:0];
      cap_ok    <= s_tdata[64];
      cap_idx   <= s_tdata[76:65];
      cap_gen   <= s_tdata[108:77];
      cap_scope <= s_tdata[140:109];
    end
  end

  // Compare the slot just read
  assign eff_gen   = rd_init ? rd_word.gen : '0;
  assign key_hit   = rd_loaded && (rd_word.key == cap_key);
  assign scope_hit = rd_loaded && (rd_word.scope == cap_scope);
  assign hnd_hit   = rd_loaded && (eff_gen == cap_gen);
  assign share_en  = cmd.ev_scan && (cap_act == ACT_LOAD) && key_hit;
  assign drop_en   = (cmd.ev_scan && (cap_act == ACT_SCOPE) && scope_hit) ||
                     (cmd.ev_hnd && (cap_act == ACT_RELEASE) && hnd_hit);
  assign drop_free = (rd_word.refc <= REF_W'(1));
  assign claim_gen = (eff_gen == '0) ? GEN_FIRST : eff_gen;

  // Status toward the controller
  always_comb begin
    sts.act        = cap_act;
    sts.scope_zero = (cap_scope == '0);
    sts.hnd_pre_ok = (cap_gen != '0) && ({1'b0, cap_idx} < (IDX_FW + 1)'(SLOT_COUNT)) &&
                     loaded[cap_idx[IDX_W-1:0]];
    sts.scan_last  = (scan_idx == IDX_W'(SLOT_COUNT - 1));
    sts.scan_match = key_hit;
    sts.free_now   = have_free || !rd_loaded;
    sts.load_ok    = cap_ok;
    sts.hnd_match  = hnd_hit;
    sts.out_busy   = m_tvalid && !m_tready;
  end

  // Pick the read address
  always_comb begin
    re = cmd.rd_scan || cmd.rd_hnd || cmd.rd_clm;
    ra = scan_idx;
    if (cmd.rd_hnd) ra = cap_idx[IDX_W-1:0];
    else if (cmd.rd_clm) ra = free_idx;
  end

  // Build the write-back word
  always_comb begin
    we = 1'b0;
    wd = rd_word;
    if (share_en) begin
      we = 1'b1;
      if (rd_word.refc != '1) wd.refc = rd_word.refc + REF_W'(1);
    end
    if (drop_en) begin
      we = 1'b1;
      if (drop_free) begin
        wd.refc = '0;
        wd.gen  = eff_gen + GEN_W'(1);
      end else begin
        wd.refc = rd_word.refc - REF_W'(1);
      end
    end
    if (cmd.ev_clm) begin
      we       = 1'b1;
      wd.gen   = claim_gen;
      wd.refc  = REF_W'(1);
      wd.scope = cur_scope;
      wd.key   = cap_key;
    end
  end

  // Slot memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[rd_addr] <= wd;
    if (re) rd_word <= mem[ra];
  end

  // Flags read alongside the memory
  always_ff @(posedge clk) begin
    if (re) begin
      rd_addr   <= ra;
      rd_loaded <= loaded[ra];
      rd_init   <= written[ra];
    end
  end

  // Loaded and written flags, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded  <= '0;
      written <= '0;
      live    <= '0;
      claims  <= '0;
    end else begin
      if (we) written[rd_addr] <= 1'b1;
      if (drop_en && drop_free) begin
        loaded[rd_addr] <= 1'b0;
        live <= live - LIVE_W'(1);
      end
      if (cmd.ev_clm) begin
        loaded[rd_addr] <= 1'b1;
        live   <= live + LIVE_W'(1);
        claims <= claims + TOTAL_W'(1);
      end
    end
  end

  // Scan index and first empty slot
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx  <= '0;
      have_free <= 1'b0;
    end else begin
      if (cmd.scan_inc) scan_idx <= scan_idx + IDX_W'(1);
      if (cmd.ev_scan && (cap_act == ACT_LOAD) && !rd_loaded && !have_free) begin
        free_idx  <= rd_addr;
        have_free <= 1'b1;
      end
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_idx    <= '0;
      res_gen    <= '0;
      res_status <= ST_STALE;
    end else begin
      if (share_en) begin
        res_status <= ST_SHARED;
        res_idx    <= IDX_FW'(rd_addr);
        res_gen    <= eff_gen;
      end
      if (cmd.ev_hnd && drop_en) res_status <= drop_free ? ST_FREED : ST_HELD;
      if (cmd.ev_clm) begin
        res_status <= ST_NEW;
        res_idx    <= IDX_FW'(rd_addr);
        res_gen    <= claim_gen;
      end
      if (cmd.st_en) res_status <= cmd.st_code;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.fin) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      m_tdata <= {7'b0, claims, live, res_gen, res_idx};
      m_tuser <= res_status;
    end
  end

endmodule

>>> hw/rtl/generational_refcounted_slot_table_core.sv
// Top level of the generational reference-counted slot table.
// Depends on grst_pkg, grst_ctrl, grst_dp and assert_macros.svh.
//
// Channel  Dir  Payload
// s_*      in   tuser: action[1:0]; tdata: key_id, load_ok, slot_index,
//               handle_gen, release_scope_id
// m_*      out  tuser: status[2:0]; tdata: result_index, result_gen,
//               live_count, loaded_total
// cfg_*    in   current_scope write, no read-back
//
// One transaction at a time. After acceptance and dispatch, release and validate
// read and check the handle's slot, or go straight to the result when the handle
// fails on index, generation zero or an empty slot; a load reads and evaluates
// each slot scanned, then reads and writes the free slot for a claim; a scope
// release scans every slot, or finishes at once for scope zero. The controller
// returns to idle before the next acceptance. The scan rate is set by the slot
// memory's single read port and registered read. Reset is synchronous and clears
// all slot flags at once; no clearing pass. A stalled result holds in the output
// register; a later item can still be accepted, but its result waits until it has left.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module generational_refcounted_slot_table_core import grst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SCOPE_W-1:0]  cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [143:0]        s_tdata,   // key_id, load_ok, slot_index, handle_gen, release_scope_id
  input  logic [1:0]          s_tuser,   // action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [95:0]         m_tdata,   // result_index, result_gen, live_count, loaded_total
  output logic [2:0]          m_tuser    // status
);

  cmd_t cmd;
  sts_t sts;

  grst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Check sequencing and result consistency
  `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `ASSERT_IMPLIES(a_live_bound, m_tvalid, m_tdata[56:44] <= 13'(SLOT_COUNT), "live count too large")
  `ASSERT_IMPLIES(a_new_gen, m_tvalid && (m_tuser == ST_NEW), m_tdata[43:12] != '0, "new slot with gen 0")
  `ASSERT_IMPLIES(a_stale_gen, m_tvalid && (m_tuser == ST_STALE), m_tdata[43:0] == '0, "stale with handle")

endmodule

>>> sim/generational_refcounted_slot_table_core_tb.sv
// Self-checking testbench for the generational reference-counted slot table.
// Depends on grst_pkg and generational_refcounted_slot_table_core; a built-in
// predictor tracks the table and checks every result transaction in order.
`timescale 1ns / 1ps

module generational_refcounted_slot_table_core_tb;
  import grst_pkg::*;

  localparam int SLOTS     = 256;
  localparam int STALL_MAX = 20000;
  localparam int DRAIN_CYC = 600;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] gen;
    status_t     st;
    logic [12:0] live;
    logic [31:0] total;
  } slot_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [2:0]   m_tuser;

  // Table shadow
  bit          tbl_loaded[SLOTS];
  logic [31:0] tbl_gen[SLOTS];
  logic [31:0] tbl_ref[SLOTS];
  logic [31:0] tbl_scope[SLOTS];
  logic [63:0] tbl_key[SLOTS];
  logic [31:0] tbl_claims;
  logic [31:0] scope_reg;

  slot_result_t pending_results[$];
  logic [63:0]  key_pool[48];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  generational_refcounted_slot_table_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop one reference; free and bump generation at zero
  function automatic status_t drop_ref(int i);
    if (tbl_ref[i] > 32'd1) begin
      tbl_ref[i]--;
      return ST_HELD;
    end
    tbl_ref[i] = '0;
    tbl_loaded[i] = 1'b0;
    tbl_gen[i]++;
    return ST_FREED;
  endfunction

  function automatic bit handle_live(logic [11:0] idx, logic [31:0] hgen);
    if (hgen == 0 || idx >= SLOTS) return 1'b0;
    return tbl_loaded[idx] && tbl_gen[idx] == hgen;
  endfunction

  // Advance the table by one item and return the result it produces
  function automatic slot_result_t apply_item(action_t act, logic [63:0] key, bit ok,
                                              logic [11:0] idx, logic [31:0] hgen,
                                              logic [31:0] sc);
    slot_result_t r;
    bit found;
    int n;
    r.idx = '0;
    r.gen = '0;
    found = 1'b0;
    case (act)
      ACT_LOAD: begin
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (tbl_loaded[i] && tbl_key[i] == key) begin
            if (tbl_ref[i] != 32'hFFFF_FFFF) tbl_ref[i]++;
            r.idx = 12'(i);
            r.gen = tbl_gen[i];
            r.st = ST_SHARED;
            found = 1'b1;
          end
        end
        if (!found && !ok) begin
          r.st = ST_FAILED;
          found = 1'b1;
        end
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (!tbl_loaded[i]) begin
            if (tbl_gen[i] == 0) tbl_gen[i] = GEN_FIRST;
            tbl_loaded[i] = 1'b1;
            tbl_ref[i] = 32'd1;
            tbl_scope[i] = scope_reg;
            tbl_key[i] = key;
            tbl_claims++;
            r.idx = 12'(i);
            r.gen = tbl_gen[i];
            r.st = ST_NEW;
            found = 1'b1;
          end
        end
        if (!found) r.st = ST_FULL;
      end
      ACT_RELEASE:  r.st = handle_live(idx, hgen) ? drop_ref(idx) : ST_STALE;
      ACT_VALIDATE: r.st = handle_live(idx, hgen) ? ST_DONE : ST_STALE;
      default: begin
        if (sc == 0) begin
          r.st = ST_STALE;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (tbl_loaded[i] && tbl_scope[i] == sc) void'(drop_ref(i));
          r.st = ST_DONE;
        end
      end
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += tbl_loaded[i];
    r.live = 13'(n);
    r.total = tbl_claims;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Offer one transaction and record its expected result on acceptance
  task automatic send_item(action_t act, logic [63:0] key, bit ok, logic [11:0] idx,
                           logic [31:0] hgen, logic [31:0] sc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b0, sc, hgen, idx, ok, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_item(act, key, ok, idx, hgen, sc));
  endtask

  // Wait for the block to go idle, then write the scope register
  task automatic settle_and_set_scope(logic [31:0] sc);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sc;
    @(posedge clk);
    cfg_we <= 1'b0;
    scope_reg = sc;
  endtask

  // Pick a current handle where one exists
  task automatic pick_handle(output logic [11:0] idx, output logic [31:0] hgen);
    int start;
    start = $urandom_range(0, SLOTS - 1);
    idx = 12'(start);
    hgen = 32'd0;
    for (int k = 0; k < SLOTS; k++) begin
      if (tbl_loaded[(start + k) % SLOTS]) begin
        idx = 12'((start + k) % SLOTS);
        hgen = tbl_gen[idx];
        break;
      end
    end
  endtask

  task automatic random_item();
    action_t     act;
    logic [63:0] key;
    bit          ok;
    logic [11:0] idx;
    logic [31:0] hgen;
    logic [31:0] sc;
    int          pick;
    key  = {$urandom, $urandom};
    ok   = 1'($urandom_range(0, 1));
    idx  = 12'($urandom_range(0, 4095));
    hgen = $urandom;
    sc   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      act = ACT_LOAD;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, 47)];
      ok = $urandom_range(0, 99) < 90;
    end else if (pick < 84) begin
      act = (pick < 66) ? ACT_RELEASE : ACT_VALIDATE;
      case ($urandom_range(0, 7))
        0: ;
        1: begin
          pick_handle(idx, hgen);
          hgen = hgen - 1;
        end
        default: pick_handle(idx, hgen);
      endcase
    end else begin
      act = ACT_SCOPE;
      case ($urandom_range(0, 9))
        0: sc = 32'd0;
        1: ;
        2: sc = 32'hFFFF_FFFF;
        default: sc = $urandom_range(1, 3);
      endcase
    end
    send_item(act, key, ok, idx, hgen, sc);
  endtask

  task automatic test_directed();
    logic [11:0] idx;
    logic [31:0] hgen;
    settle_and_set_scope(32'd1);
    send_item(ACT_LOAD, 64'd0, 1'b1, 12'd0, 32'd0, 32'd0);
    send_item(ACT_LOAD, '1, 1'b1, '1, '1, '1);
    send_item(ACT_LOAD, '1, 1'b0, 12'd0, 32'd0, 32'd0);        // shared despite failed load
    send_item(ACT_LOAD, 64'h1234, 1'b0, 12'd0, 32'd0, 32'd0);  // load failure
    send_item(ACT_VALIDATE, 64'd0, 1'b0, 12'd0, 32'd1, 32'd0);
    send_item(ACT_VALIDATE, 64'd0, 1'b0, 12'd0, 32'd0, 32'd0); // generation zero
    send_item(ACT_VALIDATE, 64'd0, 1'b0, 12'd256, 32'd1, 32'd0);
    send_item(ACT_RELEASE, 64'd0, 1'b0, 12'd4095, 32'd1, 32'd0);
    send_item(ACT_RELEASE, 64'd0, 1'b0, 12'd1, '1, 32'd0);     // mismatched generation
    send_item(ACT_RELEASE, 64'd0, 1'b0, 12'd2, 32'd1, 32'd0);  // empty slot
    send_item(ACT_RELEASE, 64'd0, 1'b0, 12'd1, 32'd1, 32'd0);  // still held
    send_item(ACT_RELEASE, 64'd0, 1'b0, 12'd1, 32'd1, 32'd0);  // freed
    send_item(ACT_VALIDATE, 64'd0, 1'b0, 12'd1, 32'd1, 32'd0); // now stale
    send_item(ACT_LOAD, 64'h55, 1'b1, 12'd0, 32'd0, 32'd0);    // reclaims slot 1, gen 2
    send_item(ACT_SCOPE, 64'd0, 1'b0, 12'd0, 32'd0, 32'd0);    // scope zero
    send_item(ACT_SCOPE, 64'd0, 1'b0, 12'd0, 32'd0, '1);
    send_item(ACT_SCOPE, 64'd0, 1'b0, 12'd0, 32'd0, 32'd1);
    settle_and_set_scope(32'hFFFF_FFFF);
    send_item(ACT_LOAD, 64'h77, 1'b1, 12'd0, 32'd0, 32'd0);
    pick_handle(idx, hgen);
    send_item(ACT_VALIDATE, 64'd0, 1'b1, idx, hgen, 32'd0);
    send_item(ACT_SCOPE, 64'd0, 1'b0, 12'd0, 32'd0, '1);
  endtask

  // Fill every slot, hit the full and failed-load cases, then release every slot by handle
  task automatic test_full_table();
    settle_and_set_scope(32'd0);
    for (int i = 0; i < SLOTS; i++)
      send_item(ACT_LOAD, {32'hA5A5_0000, i}, 1'b1, 12'd0, 32'd0, 32'd0);
    send_item(ACT_LOAD, 64'hDEAD, 1'b1, 12'd0, 32'd0, 32'd0);
    send_item(ACT_LOAD, 64'hDEAD, 1'b0, 12'd0, 32'd0, 32'd0);
    send_item(ACT_LOAD, {32'hA5A5_0000, 32'd7}, 1'b1, 12'd0, 32'd0, 32'd0);
    for (int i = 0; i < SLOTS; i++)
      send_item(ACT_RELEASE, 64'd0, 1'b0, 12'(i), tbl_gen[i], 32'd0);
    send_item(ACT_RELEASE, 64'd0, 1'b0, 12'd7, tbl_gen[7], 32'd0);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct, logic [31:0] sc);
    settle_and_set_scope(sc);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) random_item();
  endtask

  // Hold the result side off while items keep coming
  task automatic test_backpressure();
    settle_and_set_scope(32'd2);
    send_idle_pct = 0;
    hold_left = 3000;
    repeat (30) random_item();
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 32'(m_tuser), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[11:0] !== want.idx)
          report("result_index", 32'(m_tdata[11:0]), 32'(want.idx));
        if (m_tdata[43:12] !== want.gen) report("result_gen", m_tdata[43:12], want.gen);
        if (m_tuser !== want.st) report("status", 32'(m_tuser), 32'(want.st));
        if (m_tdata[56:44] !== want.live)
          report("live_count", 32'(m_tdata[56:44]), 32'(want.live));
        if (m_tdata[88:57] !== want.total) report("loaded_total", m_tdata[88:57], want.total);
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
    // Watchdog on transactions in either direction
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    scope_reg = '0;
    tbl_claims = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_loaded[i] = 1'b0;
      tbl_gen[i] = '0;
      tbl_ref[i] = '0;
      tbl_scope[i] = '0;
      tbl_key[i] = '0;
    end
    for (int i = 0; i < 48; i++) key_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(550, 28, 88, 32'd3);
    test_random(550, 88, 28, 32'd1);
    test_backpressure();
    test_random(700, 0, 0, 32'hFFFF_FFFF);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
